// ----- sv/swcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor word CRC deframer package
// Shared constants, types and the CRC-8 byte step for the deframer.
// ----------------------------------------------------------------------------
package swcd_pkg;

	localparam int unsigned MAX_WORDS   = 16;
	localparam int unsigned FRAME_CAP   = (MAX_WORDS < 16) ? ((MAX_WORDS < 1) ? 1 : MAX_WORDS) : 16;

	localparam logic [7:0]  CRC_POLY      = 8'h31;
	localparam logic [7:0]  CRC_INIT      = 8'hFF;
	localparam logic [7:0]  CRC_MSB       = 8'h80;
	localparam logic [15:0] SENT_SIGNED   = 16'h7FFF;
	localparam logic [15:0] SENT_UNSIGNED = 16'hFFFF;

	localparam logic [4:0]  WPF_RESET      = 5'd9;
	localparam logic [15:0] SIGNED_RESET   = 16'd240;
	localparam logic [15:0] SENTINEL_RESET = 16'd511;

	typedef enum logic [1:0] {
		CFG_WORDS_PER_FRAME = 2'd0,
		CFG_SIGNED_MASK     = 2'd1,
		CFG_SENTINEL_MASK   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_CRC  = 2'd2
	} phase_t;

	// One byte of CRC-8, MSB first, no final xor
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/sensor_word_crc_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Sensor word CRC deframer
// Rebuilds 16-bit words from high/low/CRC byte triplets and checks each CRC.
// ----------------------------------------------------------------------------
// Timing: a word's CRC byte beat is taken into the input register, and its
// result is then loaded into the result register once that is free.
// Throughput: one byte beat per cycle while no CRC byte waits on a full,
// stalled result register; the CRC step itself is combinational.
// Reset (arst_n low, asynchronous): byte phase, counters, error flag and
// valids clear, CRC restarts at 0xFF, registers take their default values.
module sensor_word_crc_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] data_word,
	output logic [3:0]  word_index,
	output logic        crc_ok,
	output logic        value_valid,
	output logic        frame_error,
	output logic        last_word,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers; writes are always taken
	// ------------------------------------------------------------------
	logic [4:0]  wpf_q;
	logic [15:0] signed_mask_q;
	logic [15:0] sentinel_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpf_q           <= swcd_pkg::WPF_RESET;
			signed_mask_q   <= swcd_pkg::SIGNED_RESET;
			sentinel_mask_q <= swcd_pkg::SENTINEL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				swcd_pkg::CFG_WORDS_PER_FRAME: wpf_q           <= cfg_data[4:0];
				swcd_pkg::CFG_SIGNED_MASK:     signed_mask_q   <= cfg_data;
				swcd_pkg::CFG_SENTINEL_MASK:   sentinel_mask_q <= cfg_data;
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	// Effective frame length: zero acts as one, clip to the cap
	localparam logic [4:0] FRAME_CAP_W = 5'(swcd_pkg::FRAME_CAP);
	logic [4:0] frame_len;
	always_comb begin
		frame_len = wpf_q;
		if (frame_len == 5'd0) begin
			frame_len = 5'd1;
		end
		if (frame_len > FRAME_CAP_W) begin
			frame_len = FRAME_CAP_W;
		end
	end

	// ------------------------------------------------------------------
	// Input register (stage 1)
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// ------------------------------------------------------------------
	// Deframing state
	// ------------------------------------------------------------------
	swcd_pkg::phase_t phase_q;
	logic [7:0]       high_q;
	logic [7:0]       low_q;
	logic [7:0]       crc_q;
	logic [3:0]       count_q;
	logic             err_q;

	// Output register
	logic        out_valid_q;
	logic [15:0] word_q;
	logic [3:0]  index_q;
	logic        ok_q;
	logic        vvalid_q;
	logic        ferr_q;
	logic        last_q;

	// ------------------------------------------------------------------
	// Stage-1 combinational work: one byte, one step of state
	// ------------------------------------------------------------------
	swcd_pkg::phase_t phase_eff;
	logic [3:0]       count_eff;
	logic             err_eff;
	logic [7:0]       crc_eff;
	logic             is_crc_byte;
	logic [15:0]      word_c;
	logic             ok_c;
	logic [15:0]      sent_c;
	logic             vvalid_c;
	logic [4:0]       next_idx;
	logic             last_c;
	logic             err_c;

	always_comb begin
		// A frame start drops any partial triplet and restarts the frame
		phase_eff = start_s1 ? swcd_pkg::PH_HIGH : phase_q;
		count_eff = start_s1 ? 4'd0 : count_q;
		err_eff   = start_s1 ? 1'b0 : err_q;
		crc_eff   = start_s1 ? swcd_pkg::CRC_INIT : crc_q;

		is_crc_byte = (phase_eff == swcd_pkg::PH_CRC);

		word_c   = {high_q, low_q};
		ok_c     = (crc_eff == byte_s1);
		sent_c   = signed_mask_q[count_eff] ? swcd_pkg::SENT_SIGNED
		                                    : swcd_pkg::SENT_UNSIGNED;
		vvalid_c = !(sentinel_mask_q[count_eff] && (word_c == sent_c));
		next_idx = {1'b0, count_eff} + 5'd1;
		last_c   = (next_idx >= frame_len);
		err_c    = err_eff | !ok_c;
	end

	// ------------------------------------------------------------------
	// Flow control: stage 1 moves unless it holds a result and the
	// output register is full and stalled
	// ------------------------------------------------------------------
	logic out_free;
	logic s1_go;
	logic in_take;
	logic out_load;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = valid_s1 && (!is_crc_byte || out_free);
	assign in_stall = valid_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;
	assign out_load = s1_go && is_crc_byte;

	// Control part of stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload part of stage 1: hold while stalled
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= rx_byte;
			start_s1 <= frame_start;
		end
	end

	// ------------------------------------------------------------------
	// State update: advance once per beat leaving stage 1
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= swcd_pkg::PH_HIGH;
			high_q  <= 8'h00;
			low_q   <= 8'h00;
			crc_q   <= swcd_pkg::CRC_INIT;
			count_q <= 4'd0;
			err_q   <= 1'b0;
		end else if (s1_go) begin
			unique case (phase_eff)
				swcd_pkg::PH_LOW: begin
					low_q   <= byte_s1;
					crc_q   <= swcd_pkg::crc8_step(crc_eff, byte_s1);
					phase_q <= swcd_pkg::PH_CRC;
					count_q <= count_eff;
					err_q   <= err_eff;
				end
				swcd_pkg::PH_CRC: begin
					// Triplet complete: restart CRC, step or wrap the word count
					phase_q <= swcd_pkg::PH_HIGH;
					crc_q   <= swcd_pkg::CRC_INIT;
					count_q <= last_c ? 4'd0 : next_idx[3:0];
					err_q   <= last_c ? 1'b0 : err_c;
				end
				default: begin
					// High byte; an unused phase code also lands here
					high_q  <= byte_s1;
					crc_q   <= swcd_pkg::crc8_step(swcd_pkg::CRC_INIT, byte_s1);
					phase_q <= swcd_pkg::PH_LOW;
					count_q <= count_eff;
					err_q   <= err_eff;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result register: load on a completed triplet, drop once taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			word_q   <= word_c;
			index_q  <= count_eff;
			ok_q     <= ok_c;
			vvalid_q <= vvalid_c;
			ferr_q   <= err_c;
			last_q   <= last_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_word   = word_q;
	assign word_index  = index_q;
	assign crc_ok      = ok_q;
	assign value_valid = vvalid_q;
	assign frame_error = ferr_q;
	assign last_word   = last_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor word CRC deframer testbench
// Streams response bytes into the deframer and predicts each word result:
// the assembled word, its position, the CRC-8 verdict, the sentinel verdict,
// the sticky frame error and the last-word mark. A short directed part comes
// first, then random frames under random backpressure and several register
// settings. Every result is compared in order against the prediction.
// ----------------------------------------------------------------------------
module tb;
	import swcd_pkg::*;

	localparam int unsigned SETTLE_CYCLES      = 4;
	localparam int unsigned WATCHDOG_LIMIT     = 2000;
	localparam int unsigned LONG_HOLD_CYCLES   = 300;
	localparam int unsigned RANDOM_PHASE_BYTES = 50;
	localparam int unsigned REPORT_LIMIT       = 10;
	// register index the block does not decode; writes to it must change nothing
	localparam logic [1:0]  CFG_SPARE          = 2'd3;

	typedef struct packed {
		logic [15:0] data_word;
		logic [3:0]  word_index;
		logic        crc_ok;
		logic        value_valid;
		logic        frame_error;
		logic        last_word;
	} word_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        frame_start;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] data_word;
	logic [3:0]  word_index;
	logic        crc_ok;
	logic        value_valid;
	logic        frame_error;
	logic        last_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// predictor copy of the registers and of the deframing state
	logic [4:0]  cfg_wpf;
	logic [15:0] cfg_signed;
	logic [15:0] cfg_sentinel;
	phase_t      ph_now;
	logic [7:0]  hold_hi;
	logic [7:0]  hold_lo;
	logic [7:0]  crc_acc;
	logic [3:0]  word_pos;
	logic        frame_err;

	word_result_t expected_words[$];

	int unsigned n_bytes;
	int unsigned n_words_seen;
	int unsigned n_crc_bad;
	int unsigned n_sentinel;
	int unsigned n_cfg_writes;
	int unsigned n_mismatch;

	// traffic shaping, set by the tests
	bit          tx_idle_en = 1'b0;
	bit          rx_idle_en = 1'b0;
	int unsigned rx_hold_len = 0;

	sensor_word_crc_deframer_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_word   (data_word),
		.word_index  (word_index),
		.crc_ok      (crc_ok),
		.value_valid (value_valid),
		.frame_error (frame_error),
		.last_word   (last_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// CRC-8, poly 0x31, shifted one message bit at a time, MSB first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// effective frame length: zero acts as one, clamp at the cap
	function automatic int unsigned frame_words();
		int unsigned n;
		n = cfg_wpf;
		if (n < 1) begin
			n = 1;
		end
		if (n > FRAME_CAP) begin
			n = FRAME_CAP;
		end
		return n;
	endfunction

	// Advance the predicted deframer by one accepted byte beat; a completed
	// triplet queues the word result it must produce.
	function automatic void deframe_byte(input logic [7:0] b, input logic s);
		word_result_t r;
		logic [15:0]  sent;
		if (s) begin
			// a frame start drops any partial triplet and opens word 0
			ph_now    = PH_HIGH;
			word_pos  = '0;
			frame_err = 1'b0;
			crc_acc   = CRC_INIT;
		end
		case (ph_now)
			PH_LOW: begin
				hold_lo = b;
				crc_acc = crc8_byte(crc_acc, b);
				ph_now  = PH_CRC;
			end
			PH_CRC: begin
				r.data_word  = {hold_hi, hold_lo};
				r.word_index = word_pos;
				r.crc_ok     = (crc_acc == b);
				if (!r.crc_ok) begin
					frame_err = 1'b1;
					n_crc_bad++;
				end
				r.value_valid = 1'b1;
				if (cfg_sentinel[word_pos]) begin
					sent = cfg_signed[word_pos] ? SENT_SIGNED : SENT_UNSIGNED;
					if (r.data_word == sent) begin
						r.value_valid = 1'b0;
						n_sentinel++;
					end
				end
				r.frame_error = frame_err;
				r.last_word   = (int'(word_pos) + 1 >= int'(frame_words()));
				expected_words.push_back(r);
				ph_now  = PH_HIGH;
				crc_acc = CRC_INIT;
				if (r.last_word) begin
					// bytes after the last word open a fresh frame
					word_pos  = '0;
					frame_err = 1'b0;
				end else begin
					word_pos = word_pos + 4'd1;
				end
			end
			default: begin
				hold_hi = b;
				crc_acc = crc8_byte(CRC_INIT, b);
				ph_now  = PH_LOW;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------------

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// bias words towards both sentinels and zero
	function automatic logic [15:0] rand_word();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return SENT_SIGNED;
		end
		if (r < 20) begin
			return SENT_UNSIGNED;
		end
		if (r < 25) begin
			return 16'h0000;
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offer one byte beat, hold it until taken, then predict it. Valid stays
	// high for a following beat unless a gap is drawn.
	task automatic send_byte(input logic [7:0] b, input logic s);
		int unsigned gap;
		in_valid    <= 1'b1;
		rx_byte     <= b;
		frame_start <= s;
		do @(posedge clk); while (in_stall);
		deframe_byte(b, s);
		n_bytes++;
		gap = tx_idle_en ? rand_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// send one triplet; a bad CRC byte is flipped by a random non-zero mask
	task automatic send_word(input logic [15:0] w, input logic s, input logic good);
		logic [7:0] crc;
		crc = crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
		if (!good) begin
			crc = crc ^ 8'($urandom_range(1, 255));
		end
		send_byte(w[15:8], s);
		send_byte(w[7:0], 1'b0);
		send_byte(crc, 1'b0);
	endtask

	// one register write beat; valid drops again after it
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WORDS_PER_FRAME: cfg_wpf      = val[4:0];
			CFG_SIGNED_MASK:     cfg_signed   = val;
			CFG_SENTINEL_MASK:   cfg_sentinel = val;
			default:             ;
		endcase
		n_cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering, wait for every pending word, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A frame of the current length, well formed in most cases; some frames
	// are cut short, some run past the last word, some carry stray bytes.
	task automatic send_random_frame();
		int unsigned n;
		int unsigned r;
		n = frame_words();
		r = $urandom_range(0, 99);
		if (r < 10) begin
			n = $urandom_range(1, n);
		end else if (r < 15) begin
			n = n + $urandom_range(1, 3);
		end
		for (int unsigned k = 0; k < n; k++) begin
			send_word(rand_word(), (k == 0) && ($urandom_range(0, 19) != 0),
				$urandom_range(0, 9) != 0);
			if ($urandom_range(0, 99) < 6) begin
				repeat ($urandom_range(1, 2)) begin
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stall, with a long hold-off on request
	// ------------------------------------------------------------------------
	int unsigned rx_hold_cnt = 0;
	int unsigned rx_gap_cnt = 0;

	always @(posedge clk) begin
		if (rx_hold_len != 0) begin
			rx_hold_cnt = rx_hold_len;
			rx_hold_len = 0;
		end
		if (rx_hold_cnt != 0) begin
			out_stall <= 1'b1;
			rx_hold_cnt--;
		end else if (rx_gap_cnt != 0) begin
			out_stall <= 1'b1;
			rx_gap_cnt--;
		end else begin
			out_stall <= 1'b0;
			if (rx_idle_en) begin
				rx_gap_cnt = rand_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result check: each word beat against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : word_check
		word_result_t got;
		word_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = '{data_word, word_index, crc_ok, value_valid, frame_error, last_word};
			n_words_seen++;
			if (expected_words.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= REPORT_LIMIT) begin
					$display("%0t: unexpected word %h idx %0d, nothing pending",
						$realtime, got.data_word, got.word_index);
				end
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					n_mismatch++;
					if (n_mismatch <= REPORT_LIMIT) begin
						$display("%0t: word mismatch", $realtime);
						$display("  expected word %h idx %0d crc_ok %b valid %b err %b last %b",
							want.data_word, want.word_index, want.crc_ok,
							want.value_valid, want.frame_error, want.last_word);
						$display("  actual   word %h idx %0d crc_ok %b valid %b err %b last %b",
							got.data_word, got.word_index, got.crc_ok,
							got.value_valid, got.frame_error, got.last_word);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: count cycles in which no beat moves on any channel
	// ------------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			(out_valid === 1'b1 && out_stall === 1'b0) ||
			(cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles, %0d words pending",
				$realtime, quiet_cycles, expected_words.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Default registers: the unsigned sentinel at position 0, a CRC mismatch
	// raising the frame error, and a frame start dropping a partial triplet.
	task automatic test_sentinel_and_crc();
		send_word(16'hFFFF, 1'b1, 1'b1);
		send_word(16'h0000, 1'b0, 1'b0);
		send_byte(8'h12, 1'b0);
		// restart mid-triplet; 0x7FFF is no sentinel at an unsigned position
		send_word(16'h7FFF, 1'b1, 1'b1);
		drain();
	endtask

	// Frame length out of range at both ends, words past the last word, the
	// unused register index, and both mask extremes.
	task automatic test_frame_bounds();
		write_reg(CFG_WORDS_PER_FRAME, 16'd0);
		write_reg(CFG_SIGNED_MASK, 16'hFFFF);
		write_reg(CFG_SENTINEL_MASK, 16'hFFFF);
		// length zero acts as one: every word is last, error clears after it
		send_word(16'h7FFF, 1'b1, 1'b0);
		send_word(16'h8001, 1'b0, 1'b1);
		drain();
		// 19 with upper data bits set: clamps to the cap
		write_reg(CFG_WORDS_PER_FRAME, 16'hFFF3);
		write_reg(CFG_SIGNED_MASK, 16'h0000);
		write_reg(CFG_SENTINEL_MASK, 16'h0000);
		write_reg(CFG_SPARE, 16'hA5A5);
		send_word(16'hFFFF, 1'b1, 1'b1);
		send_word(16'h00FF, 1'b1, 1'b1);
		drain();
	endtask

	// Hold the receiver off for a long stretch while bytes keep coming, so
	// the block backs up and stalls its input; then pause until all is out.
	task automatic test_backpressure();
		int unsigned mark;
		write_reg(CFG_WORDS_PER_FRAME, 16'd6);
		write_reg(CFG_SIGNED_MASK, 16'h00F0);
		write_reg(CFG_SENTINEL_MASK, 16'h003F);
		tx_idle_en  = 1'b0;
		rx_idle_en  = 1'b0;
		rx_hold_len = LONG_HOLD_CYCLES;
		mark = n_bytes;
		while (n_bytes - mark < 90) begin
			send_random_frame();
		end
		drain();
	endtask

	// Random frames under several register settings, extremes included.
	task automatic test_random_traffic();
		int unsigned mark;
		logic [15:0] v_wpf;
		logic [15:0] v_sg;
		logic [15:0] v_se;
		for (int unsigned p = 0; p < 6; p++) begin
			v_sg = 16'($urandom_range(0, 65535));
			v_se = 16'($urandom_range(0, 65535));
			case (p)
				0: begin
					v_wpf = 16'd1;
					v_sg  = 16'h0000;
					v_se  = 16'hFFFF;
				end
				1: begin
					v_wpf = 16'd16;
					v_sg  = 16'hFFFF;
					v_se  = 16'hFFFF;
				end
				2: v_wpf = 16'd0;
				3: begin
					v_wpf = 16'($urandom_range(17, 31)) | (16'($urandom) & 16'hFFE0);
					v_se  = 16'h0000;
				end
				default: v_wpf = 16'($urandom_range(2, 8));
			endcase
			drain();
			write_reg(CFG_WORDS_PER_FRAME, v_wpf);
			write_reg(CFG_SIGNED_MASK, v_sg);
			write_reg(CFG_SENTINEL_MASK, v_se);
			// first phase runs flat out on both sides
			tx_idle_en = (p != 0);
			rx_idle_en = (p != 0) && (p != 3);
			mark = n_bytes;
			while (n_bytes - mark < RANDOM_PHASE_BYTES) begin
				send_random_frame();
			end
		end
		drain();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		// drive every input to a known value and hold reset
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		rx_byte     <= '0;
		frame_start <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_WORDS_PER_FRAME;
		cfg_data    <= '0;

		// initialise the predictor to the reset state
		cfg_wpf      = WPF_RESET;
		cfg_signed   = SIGNED_RESET;
		cfg_sentinel = SENTINEL_RESET;
		ph_now       = PH_HIGH;
		hold_hi      = '0;
		hold_lo      = '0;
		crc_acc      = CRC_INIT;
		word_pos     = '0;
		frame_err    = 1'b0;
		n_bytes      = 0;
		n_words_seen = 0;
		n_crc_bad    = 0;
		n_sentinel   = 0;
		n_cfg_writes = 0;
		n_mismatch   = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sentinel_and_crc();
		test_frame_bounds();
		test_backpressure();
		test_random_traffic();

		$display("Run covered %0d byte beats, %0d word beats, %0d register writes",
			n_bytes, n_words_seen, n_cfg_writes);
		$display("  with %0d CRC mismatches and %0d sentinel readings, %0d bad results",
			n_crc_bad, n_sentinel, n_mismatch);
		if (n_mismatch == 0 && expected_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
